// ===== hw/rtl/spq_pkg.sv =====
// Package with the constants, codes and request types of the sorted priority queue.
package spq_pkg;

    localparam int CAPACITY    = 32;
    localparam int VALUE_WIDTH = 32;
    localparam int PRIO_WIDTH  = 16;
    localparam int COUNT_WIDTH = 6;

    localparam logic       OP_INSERT  = 1'b0;
    localparam logic       OP_PULL    = 1'b1;

    localparam logic [1:0] ERR_OK     = 2'd0;
    localparam logic [1:0] ERR_FULL   = 2'd1;
    localparam logic [1:0] ERR_EMPTY  = 2'd2;

    typedef struct packed {
        logic               operation;
        logic [31:0]        item_value;
        logic signed [15:0] item_priority;
    } cmd_t;

    typedef struct packed {
        logic [31:0]        head_value;
        logic signed [15:0] head_priority;
        logic [5:0]         entry_count;
        logic               is_empty;
        logic               is_full;
        logic [1:0]         error_code;
    } res_t;

    typedef struct packed {
        logic                         valid;
        logic [VALUE_WIDTH-1:0]       value;
        logic signed [PRIO_WIDTH-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic                         insert_en;
        logic                         pull_en;
        logic [VALUE_WIDTH-1:0]       new_value;
        logic signed [PRIO_WIDTH-1:0] new_prio;
    } spq_ctrl_t;

endpackage

// ===== hw/rtl/spq_cell.sv =====
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
module spq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  spq_pkg::spq_ctrl_t ctrl,
    input  spq_pkg::entry_t    prev_entry,
    input  logic               prev_keep,
    input  spq_pkg::entry_t    next_entry,
    output spq_pkg::entry_t    entry,
    output logic               keep
);
    import spq_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    logic [VALUE_WIDTH-1:0]       value_reg;
    logic [VALUE_WIDTH-1:0]       value_next;
    logic signed [PRIO_WIDTH-1:0] prio_reg;
    logic signed [PRIO_WIDTH-1:0] prio_next;

    // An entry stays in place when its priority is not below the new one.
    assign keep = valid_reg && (prio_reg >= ctrl.new_prio);

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        prio_next  = prio_reg;
        if (ctrl.insert_en)
        begin
            if (!keep)
            begin
                if (prev_keep)
                begin
                    valid_next = 1'b1;
                    value_next = ctrl.new_value;
                    prio_next  = ctrl.new_prio;
                end
                else
                begin
                    valid_next = prev_entry.valid;
                    value_next = prev_entry.value;
                    prio_next  = prev_entry.prio;
                end
            end
        end
        else if (ctrl.pull_en)
        begin
            valid_next = next_entry.valid;
            value_next = next_entry.value;
            prio_next  = next_entry.prio;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

    assign entry.valid = valid_reg;
    assign entry.value = value_reg;
    assign entry.prio  = prio_reg;

endmodule

// ===== hw/rtl/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: command decode, cell chain and result register.
//
// Usage:
// The cmd channel carries one request per accepted cycle: an insert of a value
// with a signed priority, or a pull of the highest-priority entry. The res
// channel returns one result per request: the head entry, the entry count,
// the empty and full flags and an error code for that request.
// A request is accepted when cmd_valid is high and cmd_stall is low; a result
// is taken when res_valid is high and res_stall is low.
// Every request is registered in the cell chain, so the result appears in the cycle
// after acceptance, and a new request can be accepted in every cycle that is not stalled.
// The rate is set by the row of cells, which all compare against the new
// priority and shift in the same cycle.
// While the receiver stalls a waiting result, cmd_stall is raised and the
// queue holds its contents; the result stays unchanged on res.
// Reset empties the queue and drops any pending result.
module sorted_priority_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  spq_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_stall,
    output spq_pkg::res_t res
);
    import spq_pkg::*;

    entry_t    cells [CAPACITY];
    logic      keeps [CAPACITY];
    spq_ctrl_t ctrl;

    logic                   accept;
    logic                   full;
    logic                   empty;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic                   res_valid_reg;
    logic                   res_valid_next;
    logic [1:0]             err_reg;
    logic [1:0]             err_next;

    assign cmd_stall = res_valid_reg && res_stall;
    assign accept    = cmd_valid && !cmd_stall;
    assign full      = (count_reg == COUNT_WIDTH'(CAPACITY));
    assign empty     = (count_reg == '0);

    always_comb
    begin
        ctrl.insert_en = 1'b0;
        ctrl.pull_en   = 1'b0;
        ctrl.new_value = cmd.item_value[VALUE_WIDTH-1:0];
        ctrl.new_prio  = cmd.item_priority;
        count_next     = count_reg;
        err_next       = err_reg;
        res_valid_next = res_valid_reg && res_stall;
        if (accept)
        begin
            res_valid_next = 1'b1;
            err_next       = ERR_OK;
            if (cmd.operation == OP_INSERT)
            begin
                if (full)
                begin
                    err_next = ERR_FULL;
                end
                else
                begin
                    ctrl.insert_en = 1'b1;
                    count_next     = count_reg + 1'b1;
                end
            end
            else
            begin
                if (empty)
                begin
                    err_next = ERR_EMPTY;
                end
                else
                begin
                    ctrl.pull_en = 1'b1;
                    count_next   = count_reg - 1'b1;
                end
            end
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        entry_t prev_e;
        entry_t next_e;
        logic   prev_k;

        if (i == 0)
        begin : g_first
            assign prev_e = '0;
            assign prev_k = 1'b1;
        end
        else
        begin : g_mid
            assign prev_e = cells[i-1];
            assign prev_k = keeps[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign next_e = '0;
        end
        else
        begin : g_inner
            assign next_e = cells[i+1];
        end

        spq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .prev_entry (prev_e),
            .prev_keep  (prev_k),
            .next_entry (next_e),
            .entry      (cells[i]),
            .keep       (keeps[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
            err_reg       <= ERR_OK;
        end
        else
        begin
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
            err_reg       <= err_next;
        end
    end

    // The chain and count only change on an accepted request, so the result
    // read from them holds steady while the receiver stalls.
    assign res_valid         = res_valid_reg;
    assign res.head_value    = cells[0].valid ? 32'(cells[0].value) : 32'd0;
    assign res.head_priority = cells[0].valid ? cells[0].prio : 16'sd0;
    assign res.entry_count   = 6'(count_reg);
    assign res.is_empty      = empty;
    assign res.is_full       = full;
    assign res.error_code    = err_reg;

endmodule
